// ===== hdl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the symmetric FIR decimator
// Tap format, result format, per-result job kinds and the issue handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int TAP_COUNT           = 6;
    localparam int TAP_BITS            = 16;
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int FRAC_BITS           = 13;
    localparam int COEF_BITS           = 18;
    localparam int COEF_MAX            = (1 <<< (COEF_BITS - 1)) - 1;
    localparam int COEF_MIN            = -(1 <<< (COEF_BITS - 1));
    localparam int SUM_GROWTH          = $clog2(TAP_COUNT);
    localparam int CFG_INDEX_BITS      = $clog2(TAP_COUNT);
    localparam int MAX_RESULTS         = 3;
    localparam int LEFT_BITS           = $clog2(MAX_RESULTS + 1);
    localparam int SEEN_BITS           = $clog2(TAP_COUNT + 1);
    // sample count of a row at which the first two coefficients come out
    localparam int HEAD_SEEN           = 4;

    typedef logic signed [TAP_BITS-1:0] sfd_tap_t;

    localparam sfd_tap_t TAP_RESET [TAP_COUNT] = '{
        16'sd0, -16'sd1448, 16'sd2896, 16'sd8689, 16'sd2896, -16'sd1448
    };

    // Which window taps feed one result
    typedef enum logic [3:0] {
        KIND_HEAD0,   // first coefficient of the row, left edge mirrored
        KIND_HEAD1,   // second coefficient of the row, left edge mirrored
        KIND_MID,     // interior coefficient, plain window
        KIND_EVEN0,   // tail of an odd-length row (last index even)
        KIND_EVEN1,
        KIND_EVEN2,
        KIND_ODD0,    // tail of an even-length row (last index odd)
        KIND_ODD1,
        KIND_ERR      // short row marker
    } sfd_kind_t;

    typedef struct packed {
        logic      valid;
        sfd_kind_t kind;
    } sfd_issue_t;

endpackage

// ===== hdl/sfd_window.sv =====
// ----------------------------------------------------------------------------
// sfd_window: sample window and result sequencer
// Shifts row samples into a six-deep window, works out which coefficients
// each sample releases and hands them to the ready MAC one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_window
    import sfd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          row_end,
    output sfd_issue_t                    iss,
    output logic signed [SAMPLE_BITS-1:0] iss_win [TAP_COUNT],
    input  logic                          iss_ready
);

    logic signed [SAMPLE_BITS-1:0] win_reg [TAP_COUNT];
    logic signed [SAMPLE_BITS-1:0] win_next [TAP_COUNT];
    logic [SEEN_BITS-1:0]          seen_reg;
    logic [SEEN_BITS-1:0]          seen_next;
    logic                          odd_reg;
    logic                          restart_reg;
    sfd_kind_t                     kinds_reg [MAX_RESULTS];
    sfd_kind_t                     kinds_next [MAX_RESULTS];
    sfd_kind_t                     list_kinds [MAX_RESULTS];
    logic [LEFT_BITS-1:0]          left_reg;
    logic [LEFT_BITS-1:0]          left_next;
    logic [LEFT_BITS-1:0]          list_left;
    logic [SEEN_BITS-1:0]          base_seen;
    logic                          base_odd;
    logic                          full;
    logic                          head;
    logic                          accept;
    logic                          fire;

    assign iss.valid = (left_reg != '0);
    assign iss.kind  = kinds_reg[0];
    assign iss_win   = win_reg;

    assign fire     = iss.valid && iss_ready;
    // take a new word once the last pending result leaves this cycle
    assign in_stall = iss.valid && !(left_reg == LEFT_BITS'(1) && iss_ready);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        // a finished row leaves its window in place for the tail results;
        // drop it when the next row starts
        base_seen = restart_reg ? '0 : seen_reg;
        base_odd  = restart_reg ? 1'b0 : odd_reg;
        for (int k = 0; k < TAP_COUNT - 1; k++)
        begin
            win_next[k] = restart_reg ? '0 : win_reg[k+1];
        end
        win_next[TAP_COUNT-1] = sample;
        seen_next = (base_seen == SEEN_BITS'(TAP_COUNT)) ? base_seen
                                                         : base_seen + SEEN_BITS'(1);
        full = (seen_next == SEEN_BITS'(TAP_COUNT));
        head = (seen_next == SEEN_BITS'(HEAD_SEEN));

        list_kinds = '{default: KIND_ERR};
        list_left  = '0;
        priority if (row_end && !full)
        begin
            list_kinds[0] = KIND_ERR;
            list_left     = LEFT_BITS'(1);
        end
        else if (base_odd && head)
        begin
            list_kinds[0] = KIND_HEAD0;
            list_kinds[1] = KIND_HEAD1;
            list_left     = LEFT_BITS'(2);
        end
        else if (base_odd && full && row_end)
        begin
            list_kinds[0] = KIND_MID;
            list_kinds[1] = KIND_ODD0;
            list_kinds[2] = KIND_ODD1;
            list_left     = LEFT_BITS'(3);
        end
        else if (base_odd && full)
        begin
            list_kinds[0] = KIND_MID;
            list_left     = LEFT_BITS'(1);
        end
        else if (row_end)
        begin
            list_kinds[0] = KIND_EVEN0;
            list_kinds[1] = KIND_EVEN1;
            list_kinds[2] = KIND_EVEN2;
            list_left     = LEFT_BITS'(3);
        end
        else
        begin
            // even index inside the row, or too early: release nothing
            list_left = '0;
        end

        kinds_next = kinds_reg;
        left_next  = left_reg;
        if (accept)
        begin
            kinds_next = list_kinds;
            left_next  = list_left;
        end
        else if (fire)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                kinds_next[i] = kinds_reg[i+1];
            end
            left_next = left_reg - LEFT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            odd_reg     <= 1'b0;
            restart_reg <= 1'b1;
            left_reg    <= '0;
        end
        else
        begin
            left_reg <= left_next;
            if (accept)
            begin
                seen_reg    <= seen_next;
                odd_reg     <= ~base_odd;
                restart_reg <= row_end;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kinds_reg <= kinds_next;
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (left_reg == '0 || (left_reg == LEFT_BITS'(1) && fire)))
        else $error("sfd_window: word taken while results still pending");

    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (iss.valid && iss.kind == KIND_ERR) |-> left_reg == LEFT_BITS'(1))
        else $error("sfd_window: short row marker not the only result");

    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        !restart_reg |-> (seen_reg != '0 && seen_reg <= SEEN_BITS'(TAP_COUNT)))
        else $error("sfd_window: sample count out of range inside a row");
`endif

endmodule

// ===== hdl/sfd_mac.sv =====
// ----------------------------------------------------------------------------
// sfd_mac: tap multiply, sum, scale and saturate
// Stage A picks six window samples for the result kind and multiplies them
// by the taps; stage B sums, shifts out the fraction, saturates and holds
// the result word for the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_mac
    import sfd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfd_issue_t                    iss,
    input  logic signed [SAMPLE_BITS-1:0] iss_win [TAP_COUNT],
    input  sfd_tap_t                      taps [TAP_COUNT],
    output logic                          iss_ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COEF_BITS-1:0]   coefficient,
    output logic                          row_done,
    output logic                          row_error
);

    localparam int PW = SAMPLE_BITS + TAP_BITS;
    localparam int SW = PW + SUM_GROWTH;
    localparam logic signed [SW-1:0] SAT_HI = SW'(COEF_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(COEF_MIN);

    logic signed [SAMPLE_BITS-1:0] op [TAP_COUNT];
    logic signed [PW-1:0]          prod_next [TAP_COUNT];
    logic signed [PW-1:0]          prod_reg [TAP_COUNT];
    logic                          a_valid_reg;
    logic                          a_done_reg;
    logic                          a_err_reg;
    logic                          done_next;
    logic                          err_next;
    logic                          b_ready;
    logic signed [SW-1:0]          sum;
    logic signed [SW-1:0]          shifted;
    logic signed [COEF_BITS-1:0]   coef_next;
    logic                          out_valid_reg;
    logic signed [COEF_BITS-1:0]   coefficient_reg;
    logic                          row_done_reg;
    logic                          row_error_reg;

    assign b_ready   = !out_valid_reg || !out_stall;
    assign iss_ready = !a_valid_reg || b_ready;

    // Operand order is tap 0 first; mirrored kinds fold the row edges
    always_comb
    begin
        done_next = 1'b0;
        err_next  = 1'b0;
        unique case (iss.kind)
            KIND_HEAD0: op = '{iss_win[5], iss_win[4], iss_win[3],
                               iss_win[2], iss_win[2], iss_win[3]};
            KIND_HEAD1: op = '{iss_win[3], iss_win[2], iss_win[2],
                               iss_win[3], iss_win[4], iss_win[5]};
            KIND_MID:   op = '{iss_win[0], iss_win[1], iss_win[2],
                               iss_win[3], iss_win[4], iss_win[5]};
            KIND_EVEN0: op = '{iss_win[1], iss_win[2], iss_win[3],
                               iss_win[4], iss_win[5], iss_win[5]};
            KIND_EVEN1: op = '{iss_win[3], iss_win[4], iss_win[5],
                               iss_win[5], iss_win[4], iss_win[3]};
            KIND_EVEN2:
            begin
                op = '{iss_win[5], iss_win[5], iss_win[4],
                       iss_win[3], iss_win[2], iss_win[1]};
                done_next = 1'b1;
            end
            KIND_ODD0:  op = '{iss_win[2], iss_win[3], iss_win[4],
                               iss_win[5], iss_win[5], iss_win[4]};
            KIND_ODD1:
            begin
                op = '{iss_win[4], iss_win[5], iss_win[5],
                       iss_win[4], iss_win[3], iss_win[2]};
                done_next = 1'b1;
            end
            KIND_ERR:
            begin
                op        = '{default: '0};
                done_next = 1'b1;
                err_next  = 1'b1;
            end
            default:    op = '{default: '0};
        endcase
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            prod_next[k] = op[k] * taps[k];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            sum = sum + SW'(prod_reg[k]);
        end
        // arithmetic shift rounds toward minus infinity
        shifted = sum >>> FRAC_BITS;
        if (shifted > SAT_HI)
        begin
            coef_next = COEF_BITS'(COEF_MAX);
        end
        else if (shifted < SAT_LO)
        begin
            coef_next = COEF_BITS'(COEF_MIN);
        end
        else
        begin
            coef_next = shifted[COEF_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (iss_ready)
            begin
                a_valid_reg <= iss.valid;
            end
            if (b_ready)
            begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (iss_ready && iss.valid)
        begin
            prod_reg   <= prod_next;
            a_done_reg <= done_next;
            a_err_reg  <= err_next;
        end
        if (b_ready && a_valid_reg)
        begin
            coefficient_reg <= coef_next;
            row_done_reg    <= a_done_reg;
            row_error_reg   <= a_err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign coefficient = coefficient_reg;
    assign row_done    = row_done_reg;
    assign row_error   = row_error_reg;

`ifndef SYNTHESIS
    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && row_error_reg) |-> (row_done_reg && coefficient_reg == '0))
        else $error("sfd_mac: short row word must be zero and close the row");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_ready) |=> (a_valid_reg && $stable(a_done_reg)))
        else $error("sfd_mac: product stage lost a result under stall");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(coefficient_reg)))
        else $error("sfd_mac: result word changed while stalled");
`endif

endmodule

// ===== hdl/symmetric_fir_decimator_core.sv =====
// ----------------------------------------------------------------------------
// symmetric_fir_decimator_core: 6-tap FIR, decimate by 2, mirrored row ends
// Feed one row sample per word on the input channel and mark the last one
// with row_end. Every odd sample index from 3 on releases one coefficient
// (index 3 releases two); the last sample also releases the two or three
// tail coefficients, the final one with row_done. A row shorter than six
// samples ends in one word with coefficient zero, row_done and row_error.
// Taps are written through cfg_write/cfg_index/cfg_data while idle.
// The first result of a word passes the window register, the product
// stage and the result register on its way to the output. Throughput: one
// word per cycle while in_stall is low; a word that releases several results
// holds the issue slot of the MAC until all have left, so the input stalls
// behind the sample at index 3 and the last sample. Reset restores the
// default taps and starts a fresh row. Output stall holds the result
// register; the two stages behind it fill and then the input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module symmetric_fir_decimator_core
    import sfd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [TAP_BITS-1:0]           cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          row_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COEF_BITS-1:0]   coefficient,
    output logic                          row_done,
    output logic                          row_error
);

    sfd_tap_t                      tap_reg [TAP_COUNT];
    sfd_issue_t                    iss;
    logic signed [SAMPLE_BITS-1:0] iss_win [TAP_COUNT];
    logic                          iss_ready;

    // writes to indexes past the last tap are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= TAP_RESET;
        end
        else
        begin
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                if (cfg_write && cfg_index == CFG_INDEX_BITS'(i))
                begin
                    tap_reg[i] <= cfg_data;
                end
            end
        end
    end

    sfd_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .row_end   (row_end),
        .iss       (iss),
        .iss_win   (iss_win),
        .iss_ready (iss_ready)
    );

    sfd_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .iss         (iss),
        .iss_win     (iss_win),
        .taps        (tap_reg),
        .iss_ready   (iss_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .coefficient (coefficient),
        .row_done    (row_done),
        .row_error   (row_error)
    );

endmodule

// ===== tb/sv/symmetric_fir_decimator_core_tb.sv =====
// ----------------------------------------------------------------------------
// symmetric_fir_decimator_core_tb: self-checking bench of the FIR decimator
// Streams rows of samples through the core under several tap settings and
// predicts every coefficient from a cycle-free copy of the row window with
// mirrored edges. Short rows, tap and sample extremes, random rows, output
// hold-off, drained pauses and full-rate stretches are covered; each result
// word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module symmetric_fir_decimator_core_tb;
    import sfd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 60;
    localparam int MAX_REPORTS   = 10;
    localparam int WIN_LAST      = TAP_COUNT - 1;
    localparam int CFG_SLOTS     = 2 ** CFG_INDEX_BITS;

    typedef logic signed [SAMPLE_BITS_DEFAULT-1:0] sample_t;

    localparam sample_t  SAMPLE_MAX = {1'b0, {(SAMPLE_BITS_DEFAULT-1){1'b1}}};
    localparam sample_t  SAMPLE_MIN = {1'b1, {(SAMPLE_BITS_DEFAULT-1){1'b0}}};
    localparam sfd_tap_t TAP_MAX    = {1'b0, {(TAP_BITS-1){1'b1}}};
    localparam sfd_tap_t TAP_MIN    = {1'b1, {(TAP_BITS-1){1'b0}}};

    typedef struct {
        logic signed [COEF_BITS-1:0] coef;
        logic                        done;
        logic                        err;
    } coef_word_t;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [TAP_BITS-1:0]         cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    sample_t                     sample    = '0;
    logic                        row_end   = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [COEF_BITS-1:0] coefficient;
    logic                        row_done;
    logic                        row_error;

    // predictor state: taps as written, row window with the newest sample last
    sfd_tap_t   tap_copy [TAP_COUNT];
    sample_t    row_window [TAP_COUNT];
    int         seen_in_row;
    bit         odd_index;
    coef_word_t predicted_coefs [$];
    coef_word_t oldest;

    int mismatches      = 0;
    int results_checked = 0;
    int words_sent      = 0;
    int rows_sent       = 0;
    int short_rows      = 0;
    int tap_settings    = 0;
    bit steady          = 1'b0;
    bit hold_request    = 1'b0;

    symmetric_fir_decimator_core i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic sample_t pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return SAMPLE_MAX;
        if (roll < 24)
            return SAMPLE_MIN;
        if (roll < 34)
            return sample_t'(int'($urandom_range(8)) - 4);
        return sample_t'($urandom);
    endfunction

    function automatic int pick_row_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return $urandom_range(TAP_COUNT - 1, 1);
        if (roll < 85)
            return $urandom_range(16, TAP_COUNT);
        return $urandom_range(40, 17);
    endfunction

    function automatic void clear_row();
        foreach (row_window[i])
            row_window[i] = '0;
        seen_in_row = 0;
        odd_index   = 1'b0;
    endfunction

    // Offset r from the newest sample; mirror past the row end and before its start.
    function automatic sample_t window_at(int r, int newest, bit ended);
        int t;
        if (ended && r > 0)
            r = 1 - r;
        t = newest + r;
        if (t < 0)
            r = (-t - 1) - newest;
        if (r > 0)
            r = 0;
        if (r < -WIN_LAST)
            r = -WIN_LAST;
        return row_window[WIN_LAST + r];
    endfunction

    function automatic logic signed [COEF_BITS-1:0] filter_output(int base, int newest,
                                                                  bit ended);
        longint acc;
        longint q;
        acc = 0;
        for (int k = 0; k < TAP_COUNT; k++)
            acc += longint'(tap_copy[k]) * longint'(window_at(base + k, newest, ended));
        q = acc >>> FRAC_BITS;
        if (q > COEF_MAX)
            q = COEF_MAX;
        if (q < COEF_MIN)
            q = COEF_MIN;
        return q[COEF_BITS-1:0];
    endfunction

    function automatic void push_coef(logic signed [COEF_BITS-1:0] c, logic done, logic err);
        coef_word_t w;
        w.coef = c;
        w.done = done;
        w.err  = err;
        predicted_coefs.push_back(w);
    endfunction

    function automatic void predict_word(sample_t x, bit ended);
        bit odd;
        int newest;
        int tail_base;
        int tail_count;
        odd = odd_index;
        for (int i = 0; i < WIN_LAST; i++)
            row_window[i] = row_window[i + 1];
        row_window[WIN_LAST] = x;
        if (seen_in_row < TAP_COUNT)
            seen_in_row++;
        odd_index = !odd_index;
        newest = seen_in_row - 1;
        if (ended && seen_in_row < TAP_COUNT)
        begin
            push_coef('0, 1'b1, 1'b1);
            clear_row();
            return;
        end
        // base is the window offset of tap 0; the head pair reaches before the row start
        if (odd && newest == HEAD_SEEN - 1)
        begin
            push_coef(filter_output(-7, newest, 1'b0), 1'b0, 1'b0);
            push_coef(filter_output(-5, newest, 1'b0), 1'b0, 1'b0);
        end
        else if (odd && newest >= WIN_LAST)
            push_coef(filter_output(-5, newest, 1'b0), 1'b0, 1'b0);
        if (ended)
        begin
            tail_base  = odd ? -3 : -4;
            tail_count = odd ? 2 : 3;
            for (int i = 0; i < tail_count; i++)
                push_coef(filter_output(tail_base + 2 * i, newest, 1'b1),
                          i == tail_count - 1, 1'b0);
            clear_row();
        end
    endfunction

    // Entered and left at a falling edge.
    task automatic send_word(sample_t value, bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        row_end  <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_word(value, last);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_listed(sample_t vals [$]);
        foreach (vals[i])
            send_word(vals[i], i == vals.size() - 1);
        rows_sent++;
        if (vals.size() < TAP_COUNT)
            short_rows++;
    endtask

    task automatic send_row(int len);
        for (int i = 0; i < len; i++)
            send_word(pick_sample(), i == len - 1);
        rows_sent++;
        if (len < TAP_COUNT)
            short_rows++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (predicted_coefs.size() != 0);
    endtask

    task automatic write_taps(sfd_tap_t values [TAP_COUNT]);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        for (int i = 0; i < TAP_COUNT; i++)
        begin
            cfg_write   <= 1'b1;
            cfg_index   <= CFG_INDEX_BITS'(i);
            cfg_data    <= values[i];
            tap_copy[i] = values[i];
            @(negedge clk);
        end
        // indexes past the last tap hold no register
        for (int i = TAP_COUNT; i < CFG_SLOTS; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_INDEX_BITS'(i);
            cfg_data  <= TAP_BITS'($urandom);
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        tap_settings++;
    endtask

    task automatic test_random_rows(int target);
        int start;
        start = words_sent;
        while (words_sent - start < target)
            send_row(pick_row_length());
    endtask

    task automatic test_short_rows();
        sample_t row [$];
        row = {SAMPLE_MAX};
        send_listed(row);
        row = {SAMPLE_MIN, SAMPLE_MAX};
        send_listed(row);
        row = {SAMPLE_MAX, SAMPLE_MIN, sample_t'(-1), sample_t'(0)};
        send_listed(row);
        // the head pair comes out at index 3, then the row still ends in error
        row = {SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, sample_t'(1)};
        send_listed(row);
    endtask

    task automatic test_shortest_rows();
        sample_t row [$];
        row = {SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN};
        send_listed(row);
        row = {sample_t'(0), sample_t'(1), sample_t'(-1), SAMPLE_MAX, SAMPLE_MIN,
               sample_t'(-2), sample_t'(2)};
        send_listed(row);
    endtask

    task automatic test_tap_extremes();
        sfd_tap_t setting [TAP_COUNT];
        foreach (setting[i])
            setting[i] = TAP_MAX;
        write_taps(setting);
        test_random_rows(20);
        foreach (setting[i])
            setting[i] = TAP_MIN;
        write_taps(setting);
        test_random_rows(20);
        foreach (setting[i])
            setting[i] = (i % 2 == 0) ? TAP_MAX : TAP_MIN;
        write_taps(setting);
        test_random_rows(20);
        foreach (setting[i])
            setting[i] = sfd_tap_t'($urandom);
        write_taps(setting);
        test_random_rows(20);
    endtask

    task automatic test_input_backpressure();
        write_taps(TAP_RESET);
        steady       = 1'b1;
        hold_request = 1'b1;
        send_row(20);
        send_row(19);
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        for (int split = 9; split <= 10; split++)
        begin
            for (int i = 0; i < 17; i++)
            begin
                if (i == split)
                    wait_for_results();
                send_word(pick_sample(), i == 16);
            end
            rows_sent++;
        end
    endtask

    task automatic test_full_rate();
        steady = 1'b1;
        test_random_rows(20);
        steady = 1'b0;
    endtask

    // Receiver: random hold-off, plus one long hold on request.
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (predicted_coefs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word coefficient=%0d done=%b error=%b",
                             $realtime, coefficient, row_done, row_error);
            end
            else
            begin
                oldest = predicted_coefs.pop_front();
                if (coefficient !== oldest.coef || row_done !== oldest.done ||
                    row_error !== oldest.err)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected %0d/%b/%b, got %0d/%b/%b", $realtime,
                                 oldest.coef, oldest.done, oldest.err,
                                 coefficient, row_done, row_error);
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("No handshake for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, predicted_coefs.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        tap_copy = TAP_RESET;
        clear_row();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_short_rows();
        test_shortest_rows();
        test_tap_extremes();
        test_input_backpressure();
        test_drain_pause();
        test_full_rate();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Sent %0d words in %0d rows (%0d short), checked %0d result words",
                 words_sent, rows_sent, short_rows, results_checked);
        $display("over %0d tap settings with hold-off, drained pauses and full rate",
                 tap_settings);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sfd_pkg.sv
hdl/sfd_window.sv
hdl/sfd_mac.sv
hdl/symmetric_fir_decimator_core.sv
tb/sv/symmetric_fir_decimator_core_tb.sv
